>>> rtl/keyword_vote_smoother_macros.svh
// Assertion macros used by the keyword vote smoother checker.
`ifndef KEYWORD_VOTE_SMOOTHER_MACROS_SVH
`define KEYWORD_VOTE_SMOOTHER_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define KVS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("keyword vote smoother check failed");

// Next-cycle implication, disabled while reset is held.
`define KVS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("keyword vote smoother check failed");

`endif

>>> rtl/kvs_pkg.sv
// Types and constants of the keyword vote smoother.
package kvs_pkg;

  localparam int SCORE_W   = 8;
  localparam int CLS_W     = 4;
  localparam int WIN_W     = 6;
  localparam int CNT_W     = 7;
  localparam int TALLY_N   = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [CNT_W-1:0]          CNT_MAX     = 7'd127;
  localparam logic signed [SCORE_W-1:0] THRESH_RST  = 8'sd0;
  localparam logic [WIN_W-1:0]          EVAL_RST    = 6'd48;
  localparam logic [WIN_W-1:0]          OVERLAP_RST = 6'd24;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD   = 2'd0,
    CFG_EVAL_WINDOW = 2'd1,
    CFG_OVERLAP_MIN = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_VOTE,
    ST_TALLY,
    ST_SCAN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic take;
    logic vote;
    logic tally_step;
    logic scan_step;
    logic load;
  } dp_cmd_t;

  typedef struct packed {
    logic tally_due;
    logic tally_fin;
    logic scan_last;
  } dp_stat_t;

endpackage

>>> rtl/kvs_ifs.sv
// Handshake channel interfaces for score items and result items.
interface kvs_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [kvs_pkg::SCORE_W-1:0]   score;
  logic                                 frame_end;

  modport source(output valid, output score, output frame_end, input ready);
  modport sink(input valid, input score, input frame_end, output ready);
endinterface

interface kvs_out_if;
  logic                        valid;
  logic                        ready;
  logic [kvs_pkg::CLS_W-1:0]   frame_class;
  logic                        voted;
  logic                        window_done;
  logic                        detected;
  logic [kvs_pkg::CLS_W-1:0]   detected_class;
  logic [kvs_pkg::WIN_W-1:0]   detected_count;

  modport source(output valid, output frame_class, output voted, output window_done,
                 output detected, output detected_class, output detected_count,
                 input ready);
  modport sink(input valid, input frame_class, input voted, input window_done,
               input detected, input detected_class, input detected_count,
               output ready);
endinterface

>>> rtl/kvs_ram.sv
// Generic single-write, single-read RAM with registered read data.
module kvs_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/kvs_ctrl.sv
// Controller state machine that sequences frame argmax, vote, tally and result.
module kvs_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_frame_end,
  output logic               in_ready,
  input  logic               out_ready,
  output logic               out_valid,
  output kvs_pkg::dp_cmd_t   cmd,
  input  kvs_pkg::dp_stat_t  stat
);

  kvs_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= kvs_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    cmd       = '0;
    unique case (state_r)
      kvs_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.take = in_valid;
        if (in_valid && in_frame_end) begin
          state_nxt = kvs_pkg::ST_VOTE;
        end
      end
      kvs_pkg::ST_VOTE: begin
        cmd.vote  = 1'b1;
        state_nxt = stat.tally_due ? kvs_pkg::ST_TALLY : kvs_pkg::ST_DONE;
      end
      kvs_pkg::ST_TALLY: begin
        cmd.tally_step = 1'b1;
        if (stat.tally_fin) begin
          state_nxt = kvs_pkg::ST_SCAN;
        end
      end
      kvs_pkg::ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_last) begin
          state_nxt = kvs_pkg::ST_DONE;
        end
      end
      kvs_pkg::ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.load  = 1'b1;
          state_nxt = kvs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = kvs_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

>>> rtl/kvs_dp.sv
// Datapath with configuration, running argmax, vote history, class tally and result.
module kvs_dp #(
  parameter int NUM_CLASS  = 12,
  parameter int VOTE_DEPTH = 64
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  kvs_pkg::dp_cmd_t                      cmd,
  output kvs_pkg::dp_stat_t                     stat,
  input  logic signed [kvs_pkg::SCORE_W-1:0]    in_score,
  input  logic                                  in_frame_end,
  input  logic                                  cfg_we,
  input  logic [kvs_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [kvs_pkg::SCORE_W-1:0]           cfg_data,
  output logic [kvs_pkg::CLS_W-1:0]             out_frame_class,
  output logic                                  out_voted,
  output logic                                  out_window_done,
  output logic                                  out_detected,
  output logic [kvs_pkg::CLS_W-1:0]             out_detected_class,
  output logic [kvs_pkg::WIN_W-1:0]             out_detected_count
);

  localparam int AW = $clog2(VOTE_DEPTH);

  logic signed [kvs_pkg::SCORE_W-1:0] thresh_r;
  logic [kvs_pkg::WIN_W-1:0]          ewin_r;
  logic [kvs_pkg::WIN_W-1:0]          omin_r;

  logic [kvs_pkg::CLS_W-1:0]          cls_idx_r;
  logic signed [kvs_pkg::SCORE_W-1:0] best_score_r;
  logic [kvs_pkg::CLS_W-1:0]          best_cls_r;

  logic [kvs_pkg::CNT_W-1:0]          vote_count_r, cnt_nxt;
  logic                               voted_w, tally_due_w;
  logic                               voted_r, done_r;

  logic [kvs_pkg::WIN_W-1:0]          rd_idx_r;
  logic                               pend_r;
  logic                               rd_issue, rd_in_mem, ram_we;
  logic [kvs_pkg::CLS_W-1:0]          ram_rdata;
  logic [kvs_pkg::WIN_W-1:0]          tally_r [kvs_pkg::TALLY_N];

  logic [kvs_pkg::CLS_W-1:0]          scan_idx_r;
  logic [kvs_pkg::CLS_W-1:0]          win_cls_r;
  logic [kvs_pkg::WIN_W-1:0]          win_cnt_r;
  logic [kvs_pkg::WIN_W-1:0]          scan_cnt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= kvs_pkg::THRESH_RST;
      ewin_r   <= kvs_pkg::EVAL_RST;
      omin_r   <= kvs_pkg::OVERLAP_RST;
    end else if (cfg_we) begin
      unique case (kvs_pkg::cfg_idx_t'(cfg_index))
        kvs_pkg::CFG_THRESHOLD:   thresh_r <= signed'(cfg_data);
        kvs_pkg::CFG_EVAL_WINDOW: ewin_r   <= cfg_data[kvs_pkg::WIN_W-1:0];
        kvs_pkg::CFG_OVERLAP_MIN: omin_r   <= cfg_data[kvs_pkg::WIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // A frame's first score seeds the argmax; later ones under NUM_CLASS win only when larger.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cls_idx_r    <= '0;
      best_score_r <= '0;
      best_cls_r   <= '0;
    end else if (cmd.take) begin
      if (cls_idx_r == '0) begin
        best_score_r <= in_score;
        best_cls_r   <= '0;
      end else if ((32'(cls_idx_r) < NUM_CLASS) && (in_score > best_score_r)) begin
        best_score_r <= in_score;
        best_cls_r   <= cls_idx_r;
      end
      cls_idx_r <= in_frame_end ? '0 : cls_idx_r + 1'b1;
    end
  end

  assign voted_w     = best_score_r > thresh_r;
  assign cnt_nxt     = (voted_w && (vote_count_r != kvs_pkg::CNT_MAX)) ?
                       vote_count_r + 1'b1 : vote_count_r;
  assign tally_due_w = cnt_nxt > {1'b0, ewin_r};
  assign ram_we      = cmd.vote && voted_w && (32'(vote_count_r) < VOTE_DEPTH);

  assign rd_issue  = cmd.tally_step && (rd_idx_r < ewin_r);
  assign rd_in_mem = 32'(rd_idx_r) < VOTE_DEPTH;

  kvs_ram #(
    .WIDTH (kvs_pkg::CLS_W),
    .DEPTH (VOTE_DEPTH)
  ) u_hist (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(vote_count_r)),
    .wdata (best_cls_r),
    .re    (rd_issue && rd_in_mem),
    .raddr (AW'(rd_idx_r)),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vote_count_r <= '0;
      rd_idx_r     <= '0;
      pend_r       <= 1'b0;
      scan_idx_r   <= '0;
    end else begin
      if (cmd.vote) begin
        vote_count_r <= tally_due_w ? '0 : cnt_nxt;
        if (tally_due_w) begin
          rd_idx_r   <= '0;
          pend_r     <= 1'b0;
          scan_idx_r <= kvs_pkg::CLS_W'(1);
        end
      end
      if (cmd.tally_step) begin
        pend_r <= rd_issue && rd_in_mem;
        if (rd_issue) begin
          rd_idx_r <= rd_idx_r + 1'b1;
        end
      end
      if (cmd.scan_step) begin
        scan_idx_r <= scan_idx_r + 1'b1;
      end
    end
  end

  // Silence votes and slots past the history are never reported, so they are not counted.
  always_ff @(posedge clk) begin
    if (cmd.vote && tally_due_w) begin
      for (int i = 0; i < kvs_pkg::TALLY_N; i++) begin
        tally_r[i] <= '0;
      end
    end else if (pend_r && (ram_rdata != '0)) begin
      tally_r[ram_rdata] <= tally_r[ram_rdata] + 1'b1;
    end
  end

  assign scan_cnt = tally_r[scan_idx_r];

  always_ff @(posedge clk) begin
    if (cmd.vote) begin
      voted_r <= voted_w;
      done_r  <= tally_due_w;
      if (tally_due_w) begin
        win_cls_r <= kvs_pkg::CLS_W'(1);
        win_cnt_r <= '0;
      end
    end
    if (cmd.scan_step && (scan_cnt > win_cnt_r)) begin
      win_cls_r <= scan_idx_r;
      win_cnt_r <= scan_cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_frame_class    <= best_cls_r;
      out_voted          <= voted_r;
      out_window_done    <= done_r;
      out_detected       <= done_r && (win_cnt_r > omin_r);
      out_detected_class <= done_r ? win_cls_r : '0;
      out_detected_count <= done_r ? win_cnt_r : '0;
    end
  end

  assign stat.tally_due = tally_due_w;
  assign stat.tally_fin = (rd_idx_r >= ewin_r) && !pend_r;
  assign stat.scan_last = scan_idx_r == kvs_pkg::CLS_W'(NUM_CLASS - 1);

endmodule

>>> rtl/keyword_vote_smoother.sv
// Top level of the keyword vote smoother: controller, datapath and channel ports.
//
//   channel  | direction | payload
//   in_ch    | sink      | score, frame_end
//   out_ch   | source    | frame_class, voted, window_done, detected, detected_class,
//            |           | detected_count
//   cfg_*    | write     | threshold_code, eval_window, overlap_min
//
// Score items that do not end a frame are taken back to back.
// An item that ends a frame passes through the vote state and, when a tally is due, a history
// walk that reads eval_window entries, one read a cycle, then a winner search that visits
// tally counters 1 to NUM_CLASS - 1, one a cycle, before the result is loaded.
// Reset is synchronous and active low; the history needs no clearing pass.
// A stalled result waits in the output register while further non-final items are taken.
module keyword_vote_smoother #(
  parameter int NUM_CLASS  = 12,
  parameter int VOTE_DEPTH = 64
) (
  input  logic                               clk,
  input  logic                               rst_n,
  kvs_in_if.sink                             in_ch,
  kvs_out_if.source                          out_ch,
  input  logic                               cfg_we,
  input  logic [kvs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [kvs_pkg::SCORE_W-1:0]        cfg_data
);

  kvs_pkg::dp_cmd_t  cmd;
  kvs_pkg::dp_stat_t stat;

  kvs_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_frame_end (in_ch.frame_end),
    .in_ready     (in_ch.ready),
    .out_ready    (out_ch.ready),
    .out_valid    (out_ch.valid),
    .cmd          (cmd),
    .stat         (stat)
  );

  kvs_dp #(
    .NUM_CLASS  (NUM_CLASS),
    .VOTE_DEPTH (VOTE_DEPTH)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .in_score           (in_ch.score),
    .in_frame_end       (in_ch.frame_end),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .out_frame_class    (out_ch.frame_class),
    .out_voted          (out_ch.voted),
    .out_window_done    (out_ch.window_done),
    .out_detected       (out_ch.detected),
    .out_detected_class (out_ch.detected_class),
    .out_detected_count (out_ch.detected_count)
  );

endmodule

>>> rtl/kvs_chk.sv
// Port-level checker for the keyword vote smoother and its bind to the top level.
`include "keyword_vote_smoother_macros.svh"

module kvs_chk (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        in_frame_end,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [kvs_pkg::CLS_W-1:0]   out_frame_class,
  input logic                        out_voted,
  input logic                        out_window_done,
  input logic                        out_detected,
  input logic [kvs_pkg::CLS_W-1:0]   out_detected_class,
  input logic [kvs_pkg::WIN_W-1:0]   out_detected_count
);

  `KVS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable({out_frame_class, out_voted, out_window_done, out_detected, out_detected_class, out_detected_count}))

  `KVS_ASSERT_IMPLY(a_no_tally_quiet, clk, rst_n, out_valid && !out_window_done, !out_detected && (out_detected_class == '0) && (out_detected_count == '0))

  `KVS_ASSERT_IMPLY(a_tally_not_silence, clk, rst_n, out_valid && out_window_done, out_detected_class != '0)

  `KVS_ASSERT_NEXT(a_frame_end_busy, clk, rst_n, in_valid && in_ready && in_frame_end, !in_ready)

endmodule

bind keyword_vote_smoother kvs_chk u_kvs_chk (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_ch.valid),
  .in_ready           (in_ch.ready),
  .in_frame_end       (in_ch.frame_end),
  .out_valid          (out_ch.valid),
  .out_ready          (out_ch.ready),
  .out_frame_class    (out_ch.frame_class),
  .out_voted          (out_ch.voted),
  .out_window_done    (out_ch.window_done),
  .out_detected       (out_ch.detected),
  .out_detected_class (out_ch.detected_class),
  .out_detected_count (out_ch.detected_count)
);

>>> bench/tb_keyword_vote_smoother.sv
// Self-checking testbench for the keyword vote smoother: directed table, random frames.
`timescale 1ns / 1ps

module tb_keyword_vote_smoother;
  import kvs_pkg::*;

  localparam int NUM_CLASS    = 12;
  localparam int VOTE_DEPTH   = 64;
  localparam int DRAIN_CYCLES = 100;
  localparam int HOLD_CYCLES  = 400;
  localparam int PROBE_COUNT  = 23;
  localparam int PHASE_COUNT  = 9;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  typedef enum logic [1:0] {
    GAPS_NONE,
    GAPS_SENDER,
    GAPS_RECEIVER,
    GAPS_BOTH
  } gap_mode_t;

  typedef struct packed {
    logic [CLS_W-1:0] frame_class;
    logic             voted;
    logic             window_done;
    logic             detected;
    logic [CLS_W-1:0] detected_class;
    logic [WIN_W-1:0] detected_count;
  } frame_verdict_t;

  typedef struct packed {
    logic signed [SCORE_W-1:0] score;
    logic                      last;
    logic                      typed;
    frame_verdict_t            want;
  } probe_row_t;

  typedef struct packed {
    logic signed [SCORE_W-1:0] thr;
    logic [7:0]                win_data;
    logic [7:0]                ovl_data;
    gap_mode_t                 gaps;
    logic [7:0]                frames;
    logic                      brief;
    logic                      squeeze;
  } phase_t;

  localparam frame_verdict_t NO_WANT = '0;

  // Lone frames at both score extremes, an early end with a tie, then an overlong
  // frame whose scores past the last class are ignored and which wraps and restarts.
  localparam probe_row_t PROBES [PROBE_COUNT] = '{
    '{8'sd127, 1'b1, 1'b1, '{4'd0, 1'b1, 1'b0, 1'b0, 4'd0, 6'd0}},
    '{8'sh80,  1'b1, 1'b1, '{4'd0, 1'b0, 1'b0, 1'b0, 4'd0, 6'd0}},
    '{8'sd5, 1'b0, 1'b0, NO_WANT}, '{8'sd90, 1'b0, 1'b0, NO_WANT},
    '{8'sd90, 1'b1, 1'b0, NO_WANT},
    '{-8'sd100, 1'b0, 1'b0, NO_WANT}, '{8'sd20, 1'b0, 1'b0, NO_WANT},
    '{8'sd40, 1'b0, 1'b0, NO_WANT}, '{8'sd40, 1'b0, 1'b0, NO_WANT},
    '{8'sd10, 1'b0, 1'b0, NO_WANT}, '{8'sd10, 1'b0, 1'b0, NO_WANT},
    '{8'sd10, 1'b0, 1'b0, NO_WANT}, '{8'sd10, 1'b0, 1'b0, NO_WANT},
    '{8'sd10, 1'b0, 1'b0, NO_WANT}, '{8'sd10, 1'b0, 1'b0, NO_WANT},
    '{8'sd10, 1'b0, 1'b0, NO_WANT}, '{8'sd39, 1'b0, 1'b0, NO_WANT},
    '{8'sd127, 1'b0, 1'b0, NO_WANT}, '{8'sd127, 1'b0, 1'b0, NO_WANT},
    '{8'sd127, 1'b0, 1'b0, NO_WANT}, '{8'sd127, 1'b0, 1'b0, NO_WANT},
    '{-8'sd5, 1'b0, 1'b0, NO_WANT}, '{-8'sd3, 1'b1, 1'b0, NO_WANT}
  };

  localparam phase_t PHASES [PHASE_COUNT] = '{
    '{8'sd10,   8'd4,   8'd1,   GAPS_NONE,     8'd10, 1'b0, 1'b0},
    '{8'sh80,   8'd1,   8'd0,   GAPS_SENDER,   8'd12, 1'b0, 1'b0},
    '{8'sd127,  8'd2,   8'd0,   GAPS_RECEIVER, 8'd5,  1'b0, 1'b0},
    '{-8'sd20,  8'd0,   8'd63,  GAPS_BOTH,     8'd10, 1'b0, 1'b0},
    '{8'sd30,   8'd8,   8'd3,   GAPS_SENDER,   8'd12, 1'b0, 1'b0},
    '{-8'sd100, 8'd63,  8'hFF,  GAPS_NONE,     8'd90, 1'b1, 1'b0},
    '{8'sd0,    8'd6,   8'd2,   GAPS_NONE,     8'd12, 1'b0, 1'b1},
    '{8'sd50,   8'd20,  8'd5,   GAPS_BOTH,     8'd12, 1'b0, 1'b0},
    '{8'sd5,    8'hC5,  8'd1,   GAPS_RECEIVER, 8'd10, 1'b0, 1'b0}
  };

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [SCORE_W-1:0]   cfg_data;

  kvs_in_if  in_bus ();
  kvs_out_if out_bus ();

  keyword_vote_smoother #(
    .NUM_CLASS (NUM_CLASS),
    .VOTE_DEPTH(VOTE_DEPTH)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_bus),
    .out_ch   (out_bus),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  logic signed [SCORE_W-1:0] cfg_thresh;
  logic [WIN_W-1:0]          cfg_window;
  logic [WIN_W-1:0]          cfg_overlap;
  logic [CLS_W-1:0]          kw_idx;
  logic signed [SCORE_W-1:0] kw_best;
  logic [CLS_W-1:0]          kw_best_cls;
  logic [CLS_W-1:0]          vote_log [VOTE_DEPTH];
  int                        votes_held;

  frame_verdict_t expected_verdicts [$];
  frame_verdict_t want_verdict;
  frame_verdict_t got_verdict;

  logic [CLS_W-1:0] hot_class = 4'd3;
  int src_idle_pct  = 0;
  int snk_stall_pct = 0;
  int hold_requests = 0;
  int holds_served  = 0;
  int hold_left     = 0;
  int mismatches    = 0;
  int items_sent    = 0;
  int results_seen  = 0;
  int tallies_seen  = 0;
  int detects_seen  = 0;
  int settings_used = 1;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("%0t: no progress before the time limit", $realtime);
    $display("tb_keyword_vote_smoother failed");
    $finish;
  end

  function automatic bit predict_frame(input logic signed [SCORE_W-1:0] s, input logic last,
                                       output frame_verdict_t v);
    int               tally [TALLY_N];
    int               lead;
    int               i;
    logic [CLS_W-1:0] pos;
    pos = kw_idx;
    v = '0;
    if (pos == 0) begin
      kw_best = s;
      kw_best_cls = '0;
    end else if (pos < NUM_CLASS && s > kw_best) begin
      kw_best = s;
      kw_best_cls = pos;
    end
    if (!last) begin
      kw_idx = pos + 4'd1;
      return 1'b0;
    end
    kw_idx = '0;
    v.frame_class = kw_best_cls;
    if (kw_best > cfg_thresh) begin
      v.voted = 1'b1;
      if (votes_held < VOTE_DEPTH) vote_log[votes_held] = kw_best_cls;
      if (votes_held < CNT_MAX) votes_held++;
    end
    if (votes_held > cfg_window) begin
      votes_held = 0;
      foreach (tally[i]) tally[i] = 0;
      for (i = 0; i < cfg_window; i++) tally[vote_log[i]]++;
      lead = 1;
      for (i = 2; i < NUM_CLASS; i++) begin
        if (tally[i] > tally[lead]) lead = i;
      end
      v.window_done = 1'b1;
      v.detected_class = CLS_W'(lead);
      v.detected_count = WIN_W'(tally[lead]);
      v.detected = tally[lead] > cfg_overlap;
    end
    return 1'b1;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SCORE_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_THRESHOLD:   cfg_thresh = data;
      CFG_EVAL_WINDOW: cfg_window = data[WIN_W-1:0];
      CFG_OVERLAP_MIN: cfg_overlap = data[WIN_W-1:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic offer_item(input logic signed [SCORE_W-1:0] s, input logic last,
                            input logic typed, input frame_verdict_t want);
    frame_verdict_t v;
    bit             has_result;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(negedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.score <= s;
    in_bus.frame_end <= last;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    has_result = predict_frame(s, last, v);
    if (has_result) expected_verdicts.push_back(typed ? want : v);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic settle();
    in_bus.valid <= 1'b0;
    while (expected_verdicts.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic send_frame(input logic brief);
    int                        len;
    int                        pick;
    int                        flavor;
    int                        k;
    logic [CLS_W-1:0]          pos;
    logic [CLS_W-1:0]          frame_hot;
    logic signed [SCORE_W-1:0] s;
    if ($urandom_range(0, 7) == 0) hot_class = CLS_W'($urandom_range(1, NUM_CLASS - 1));
    frame_hot = ($urandom_range(0, 9) < 7) ? hot_class : 4'($urandom_range(0, 15));
    pick = $urandom_range(0, 9);
    if (brief) len = $urandom_range(1, 3);
    else if (pick == 0) len = $urandom_range(1, NUM_CLASS - 1);
    else if (pick == 1) len = $urandom_range(NUM_CLASS + 1, 20);
    else len = NUM_CLASS;
    flavor = $urandom_range(0, 7);
    for (k = 0; k < len; k++) begin
      pos = CLS_W'(k);
      if (flavor == 0) s = 8'($urandom_range(0, 255));
      else if (flavor == 1) s = 8'($urandom_range(0, 2)) - 8'd1;
      else if (pos == frame_hot) s = 8'($urandom_range(20, 127));
      else s = 8'($urandom_range(0, 147) + 128);
      offer_item(s, k == len - 1, 1'b0, NO_WANT);
    end
  endtask

  task automatic run_phase(input phase_t p);
    int f;
    settle();
    write_reg(CFG_THRESHOLD, p.thr);
    write_reg(CFG_EVAL_WINDOW, p.win_data);
    write_reg(CFG_OVERLAP_MIN, p.ovl_data);
    src_idle_pct = (p.gaps == GAPS_SENDER) ? 61 : (p.gaps == GAPS_BOTH) ? 19 : 0;
    snk_stall_pct = (p.gaps == GAPS_RECEIVER) ? 61 : (p.gaps == GAPS_BOTH) ? 19 : 0;
    if (p.squeeze) hold_requests++;
    for (f = 0; f < p.frames; f++) send_frame(p.brief);
    settings_used++;
  endtask

  always @(negedge clk) begin
    if (hold_requests != holds_served) begin
      holds_served = hold_requests;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= ($urandom_range(0, 99) >= snk_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_bus.valid && out_bus.ready) begin
      got_verdict = '{out_bus.frame_class, out_bus.voted, out_bus.window_done,
                      out_bus.detected, out_bus.detected_class, out_bus.detected_count};
      results_seen++;
      if (got_verdict.window_done) tallies_seen++;
      if (got_verdict.detected) detects_seen++;
      if (expected_verdicts.size() == 0) begin
        mismatches++;
        $display("%0t: result with nothing expected: class %0d voted %0d done %0d det %0d/%0d/%0d",
                 $realtime, got_verdict.frame_class, got_verdict.voted,
                 got_verdict.window_done, got_verdict.detected, got_verdict.detected_class,
                 got_verdict.detected_count);
      end else begin
        want_verdict = expected_verdicts.pop_front();
        if (got_verdict !== want_verdict) begin
          mismatches++;
          $display("%0t: mismatch: expected class %0d voted %0d done %0d det %0d/%0d/%0d",
                   $realtime, want_verdict.frame_class, want_verdict.voted,
                   want_verdict.window_done, want_verdict.detected,
                   want_verdict.detected_class, want_verdict.detected_count);
          $display("%0t:           actual class %0d voted %0d done %0d det %0d/%0d/%0d",
                   $realtime, got_verdict.frame_class, got_verdict.voted,
                   got_verdict.window_done, got_verdict.detected,
                   got_verdict.detected_class, got_verdict.detected_count);
        end
      end
    end
  end

  initial begin
    int i;
    rst_n = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.score = '0;
    in_bus.frame_end = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    cfg_thresh = THRESH_RST;
    cfg_window = EVAL_RST;
    cfg_overlap = OVERLAP_RST;
    kw_idx = '0;
    kw_best = '0;
    kw_best_cls = '0;
    votes_held = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    for (i = 0; i < PROBE_COUNT; i++) begin
      offer_item(PROBES[i].score, PROBES[i].last, PROBES[i].typed, PROBES[i].want);
    end
    settle();
    write_reg(CFG_SPARE, 8'h5A);
    for (i = 0; i < PHASE_COUNT; i++) run_phase(PHASES[i]);
    settle();
    $display("Sent %0d score items over %0d register settings; %0d frame results checked.",
             items_sent, settings_used, results_seen);
    $display("Results included %0d tallies, %0d of them with a detection.",
             tallies_seen, detects_seen);
    if (mismatches == 0) begin
      $display("tb_keyword_vote_smoother passed");
    end else begin
      $display("tb_keyword_vote_smoother failed");
    end
    $finish;
  end

endmodule

>>> keyword_vote_smoother.f
+incdir+rtl
rtl/kvs_pkg.sv
rtl/kvs_ifs.sv
rtl/kvs_ram.sv
rtl/kvs_ctrl.sv
rtl/kvs_dp.sv
rtl/keyword_vote_smoother.sv
rtl/kvs_chk.sv
bench/tb_keyword_vote_smoother.sv
